>>> sv/silence_boundary_refiner_assert.svh
// Assertion macros shared by the silence boundary refiner RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SILENCE_BOUNDARY_REFINER_ASSERT_SVH
`define SILENCE_BOUNDARY_REFINER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("silence_boundary_refiner: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("silence_boundary_refiner: next-cycle check failed");

`endif

>>> sv/sbr_pkg.sv
// Package for the silence boundary refiner: widths, types and codes.
// Used by the channel interfaces and the top level; depends on nothing.
package sbr_pkg;

  // Field widths
  localparam int FRAME_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int WINDOW_BITS = 16;
  localparam int THRESH_BITS = 16;
  localparam int COUNT_BITS  = WINDOW_BITS + 1;
  localparam int MAG_BITS    = (SAMPLE_BITS + 1 > THRESH_BITS) ? SAMPLE_BITS + 1 : THRESH_BITS;
  localparam int WIDE_BITS   = ((FRAME_BITS > COUNT_BITS) ? FRAME_BITS : COUNT_BITS) + 2;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = (WINDOW_BITS > THRESH_BITS) ? WINDOW_BITS : THRESH_BITS;

  typedef logic [FRAME_BITS-1:0]         frame_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WINDOW_BITS-1:0]        win_t;
  typedef logic [THRESH_BITS-1:0]        thresh_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [1:0]                    opcode_t;
  typedef logic [1:0]                    position_t;
  typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

  // Request opcodes
  localparam opcode_t OP_HEADER = 2'd0;
  localparam opcode_t OP_SAMPLE = 2'd1;
  localparam opcode_t OP_FINISH = 2'd2;

  // Region positions
  localparam position_t POS_INTERIOR = 2'd0;
  localparam position_t POS_LEADING  = 2'd1;
  localparam position_t POS_TRAILING = 2'd2;
  localparam position_t POS_ENTIRE   = 2'd3;

  // Register indexes
  localparam cfg_index_t CFG_THRESHOLD = 2'd0;
  localparam cfg_index_t CFG_ALL_MODE  = 2'd1;
  localparam cfg_index_t CFG_WINDOW    = 2'd2;

  // Register reset values
  localparam thresh_t THRESHOLD_RST = THRESH_BITS'(328);
  localparam logic    ALL_MODE_RST  = 1'b1;
  localparam win_t    WINDOW_RST    = WINDOW_BITS'(4096);

  localparam frame_t FRAME_MAX = {FRAME_BITS{1'b1}};

endpackage

>>> sv/sbr_if.sv
// Valid/ready channel interfaces of the silence boundary refiner.
// Depends on sbr_pkg for field widths.

// Request channel: header, sample and finish requests
interface sbr_in_if;
  logic                  valid;
  logic                  ready;
  sbr_pkg::opcode_t      opcode;
  sbr_pkg::frame_t       coarse_begin;
  sbr_pkg::frame_t       coarse_end;
  sbr_pkg::position_t    region_position;
  logic                  perceptual_region;
  logic                  window_select;
  sbr_pkg::sample_t      sample;
  logic                  last_channel;

  modport source (
    output valid, opcode, coarse_begin, coarse_end, region_position,
           perceptual_region, window_select, sample, last_channel,
    input  ready
  );
  modport sink (
    input  valid, opcode, coarse_begin, coarse_end, region_position,
           perceptual_region, window_select, sample, last_channel,
    output ready
  );
endinterface

// Result channel: refined region
interface sbr_out_if;
  logic            valid;
  logic            ready;
  sbr_pkg::frame_t refined_begin;
  sbr_pkg::frame_t refined_end;
  logic            reverted;

  modport source (
    output valid, refined_begin, refined_end, reverted,
    input  ready
  );
  modport sink (
    input  valid, refined_begin, refined_end, reverted,
    output ready
  );
endinterface

>>> sv/silence_boundary_refiner.sv
// Silence boundary refiner: refines one coarse silence region to frame accuracy.
// Depends on sbr_pkg, sbr_if.sv and silence_boundary_refiner_assert.svh.
//
// Usage:
//   in_ch carries requests: a header (coarse range, position, perceptual flag),
//   then channel samples of the begin and end search windows, then a finish.
//   out_ch returns one refined region per finish request; other requests
//   give no result. cfg_we/cfg_index/cfg_wdata write the threshold, the
//   channel mode and the search radius; write them only while idle.
// Timing:
//   Every request passes one input register and is resolved from it; a finish
//   loads the result register. One request per cycle is sustained unless a
//   finish waits for the result register; the per-frame search is a compare and
//   a counter update, and the finish is an add and compare per boundary.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears the search
//   state and held region, and loads the register defaults (328, 1, 4096).
// Stall:
//   While out_ch.ready is low a waiting result holds; headers and samples
//   keep flowing, and only a further finish waits for the result register.
module silence_boundary_refiner (
  input  logic                clk,
  input  logic                rst_n,
  sbr_in_if.sink              in_ch,
  sbr_out_if.source           out_ch,
  input  logic                cfg_we,
  input  sbr_pkg::cfg_index_t cfg_index,
  input  sbr_pkg::cfg_data_t  cfg_wdata
);

  `include "silence_boundary_refiner_assert.svh"

  localparam int WB = sbr_pkg::WIDE_BITS;

  // Window length: min(coarse, W) + W frames
  function automatic sbr_pkg::count_t win_length(sbr_pkg::frame_t coarse, sbr_pkg::win_t w);
    sbr_pkg::count_t near;
    near = (WB'(coarse) >= WB'(w)) ? sbr_pkg::COUNT_BITS'(w)
                                   : sbr_pkg::COUNT_BITS'(coarse);
    return near + sbr_pkg::COUNT_BITS'(w);
  endfunction

  // Boundary = window origin + offset (+1), saturated to the frame range
  function automatic sbr_pkg::frame_t refine_edge(sbr_pkg::frame_t coarse, sbr_pkg::win_t w,
                                                  sbr_pkg::count_t off, logic inc);
    logic [WB-1:0] base;
    logic [WB-1:0] sum;
    base = (WB'(coarse) >= WB'(w)) ? WB'(coarse) - WB'(w) : '0;
    sum  = base + WB'(off) + WB'(inc);
    return (sum > WB'(sbr_pkg::FRAME_MAX)) ? sbr_pkg::FRAME_MAX
                                           : sbr_pkg::FRAME_BITS'(sum);
  endfunction

  // Configuration registers
  sbr_pkg::thresh_t thr_r;
  logic             all_mode_r;
  sbr_pkg::win_t    win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= sbr_pkg::THRESHOLD_RST;
      all_mode_r <= sbr_pkg::ALL_MODE_RST;
      win_r      <= sbr_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbr_pkg::CFG_THRESHOLD: thr_r      <= sbr_pkg::THRESH_BITS'(cfg_wdata);
        sbr_pkg::CFG_ALL_MODE:  all_mode_r <= cfg_wdata[0];
        sbr_pkg::CFG_WINDOW:    win_r      <= sbr_pkg::WINDOW_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Input register
  logic                s1_v_r;
  sbr_pkg::opcode_t    s1_op_r;
  sbr_pkg::frame_t     s1_cb_r;
  sbr_pkg::frame_t     s1_ce_r;
  sbr_pkg::position_t  s1_pos_r;
  logic                s1_perc_r;
  logic                s1_wsel_r;
  sbr_pkg::sample_t    s1_smp_r;
  logic                s1_last_r;

  logic out_v_r;
  logic adv;
  logic in_ready;
  logic in_take;
  logic is_header;
  logic is_sample;
  logic is_finish;

  assign is_header = (s1_op_r == sbr_pkg::OP_HEADER);
  assign is_sample = (s1_op_r == sbr_pkg::OP_SAMPLE);
  assign is_finish = (s1_op_r == sbr_pkg::OP_FINISH);

  // A finish moves on only when the result register is free or draining
  assign adv      = s1_v_r && (!is_finish || !out_v_r || out_ch.ready);
  assign in_ready = !s1_v_r || adv;
  assign in_take  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_take || (s1_v_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_ch.opcode;
      s1_cb_r   <= in_ch.coarse_begin;
      s1_ce_r   <= in_ch.coarse_end;
      s1_pos_r  <= in_ch.region_position;
      s1_perc_r <= in_ch.perceptual_region;
      s1_wsel_r <= in_ch.window_select;
      s1_smp_r  <= in_ch.sample;
      s1_last_r <= in_ch.last_channel;
    end
  end

  // Held region and search state
  sbr_pkg::frame_t    held_b_r, held_b_nxt;
  sbr_pkg::frame_t    held_e_r, held_e_nxt;
  sbr_pkg::position_t held_pos_r, held_pos_nxt;
  logic               held_perc_r, held_perc_nxt;
  sbr_pkg::count_t    cnt_b_r, cnt_b_nxt;
  sbr_pkg::count_t    cnt_e_r, cnt_e_nxt;
  logic               fall_r, fall_nxt;
  logic               fany_r, fany_nxt;
  logic               last_seen_r, last_seen_nxt;
  sbr_pkg::count_t    last_off_r, last_off_nxt;
  logic               first_seen_r, first_seen_nxt;
  sbr_pkg::count_t    first_off_r, first_off_nxt;

  // Channel magnitude test
  logic [sbr_pkg::SAMPLE_BITS:0] smp_ext;
  logic [sbr_pkg::SAMPLE_BITS:0] mag;
  logic                          ch_silent;
  logic                          all_now;
  logic                          any_now;
  logic                          frame_loud;

  assign smp_ext    = {s1_smp_r[sbr_pkg::SAMPLE_BITS-1], s1_smp_r};
  assign mag        = s1_smp_r[sbr_pkg::SAMPLE_BITS-1] ? ('0 - smp_ext) : smp_ext;
  assign ch_silent  = sbr_pkg::MAG_BITS'(mag) <= sbr_pkg::MAG_BITS'(thr_r);
  assign all_now    = fall_r && ch_silent;
  assign any_now    = fany_r || ch_silent;
  assign frame_loud = all_mode_r ? !all_now : !any_now;

  always_comb begin
    held_b_nxt     = held_b_r;
    held_e_nxt     = held_e_r;
    held_pos_nxt   = held_pos_r;
    held_perc_nxt  = held_perc_r;
    cnt_b_nxt      = cnt_b_r;
    cnt_e_nxt      = cnt_e_r;
    fall_nxt       = fall_r;
    fany_nxt       = fany_r;
    last_seen_nxt  = last_seen_r;
    last_off_nxt   = last_off_r;
    first_seen_nxt = first_seen_r;
    first_off_nxt  = first_off_r;
    if (adv) begin
      unique case (s1_op_r)
        sbr_pkg::OP_HEADER: begin
          held_b_nxt     = s1_cb_r;
          held_e_nxt     = s1_ce_r;
          held_pos_nxt   = s1_pos_r;
          held_perc_nxt  = s1_perc_r;
          cnt_b_nxt      = '0;
          cnt_e_nxt      = '0;
          fall_nxt       = 1'b1;
          fany_nxt       = 1'b0;
          last_seen_nxt  = 1'b0;
          last_off_nxt   = '0;
          first_seen_nxt = 1'b0;
          first_off_nxt  = '0;
        end
        sbr_pkg::OP_SAMPLE: begin
          fall_nxt = all_now;
          fany_nxt = any_now;
          if (s1_last_r) begin
            // frame closes: count it in its window if the window has room
            if (!s1_wsel_r) begin
              if (cnt_b_r < win_length(held_b_r, win_r)) begin
                if (frame_loud) begin
                  last_seen_nxt = 1'b1;
                  last_off_nxt  = cnt_b_r;
                end
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end else begin
              if (cnt_e_r < win_length(held_e_r, win_r)) begin
                if (frame_loud && !first_seen_r) begin
                  first_seen_nxt = 1'b1;
                  first_off_nxt  = cnt_e_r;
                end
                cnt_e_nxt = cnt_e_r + 1'b1;
              end
            end
            fall_nxt = 1'b1;
            fany_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_b_r     <= '0;
      held_e_r     <= '0;
      held_pos_r   <= sbr_pkg::POS_INTERIOR;
      held_perc_r  <= 1'b0;
      cnt_b_r      <= '0;
      cnt_e_r      <= '0;
      fall_r       <= 1'b1;
      fany_r       <= 1'b0;
      last_seen_r  <= 1'b0;
      last_off_r   <= '0;
      first_seen_r <= 1'b0;
      first_off_r  <= '0;
    end else begin
      held_b_r     <= held_b_nxt;
      held_e_r     <= held_e_nxt;
      held_pos_r   <= held_pos_nxt;
      held_perc_r  <= held_perc_nxt;
      cnt_b_r      <= cnt_b_nxt;
      cnt_e_r      <= cnt_e_nxt;
      fall_r       <= fall_nxt;
      fany_r       <= fany_nxt;
      last_seen_r  <= last_seen_nxt;
      last_off_r   <= last_off_nxt;
      first_seen_r <= first_seen_nxt;
      first_off_r  <= first_off_nxt;
    end
  end

  // Finish: refined boundaries, position skips and collapse check
  logic            move_b;
  logic            move_e;
  sbr_pkg::frame_t rb;
  sbr_pkg::frame_t re;
  sbr_pkg::frame_t res_b;
  sbr_pkg::frame_t res_e;
  logic            res_rev;

  assign move_b = last_seen_r && (held_pos_r != sbr_pkg::POS_LEADING)
                  && (held_pos_r != sbr_pkg::POS_ENTIRE);
  assign move_e = first_seen_r && (held_pos_r != sbr_pkg::POS_TRAILING)
                  && (held_pos_r != sbr_pkg::POS_ENTIRE);
  assign rb = move_b ? refine_edge(held_b_r, win_r, last_off_r, 1'b1) : held_b_r;
  assign re = move_e ? refine_edge(held_e_r, win_r, first_off_r, 1'b0) : held_e_r;

  always_comb begin
    res_b   = held_b_r;
    res_e   = held_e_r;
    res_rev = 1'b0;
    if (!held_perc_r) begin
      if (re <= rb) begin
        res_rev = 1'b1;
      end else begin
        res_b = rb;
        res_e = re;
      end
    end
  end

  // Result register
  logic            fin_go;
  sbr_pkg::frame_t out_b_r;
  sbr_pkg::frame_t out_e_r;
  logic            out_rev_r;

  assign fin_go = adv && is_finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= fin_go || (out_v_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_b_r   <= res_b;
      out_e_r   <= res_e;
      out_rev_r <= res_rev;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.refined_begin = out_b_r;
  assign out_ch.refined_end   = out_e_r;
  assign out_ch.reverted      = out_rev_r;

  // Checks
  `SBR_ASSERT_NOW(a_empty_takes, !s1_v_r, in_ready)
  `SBR_ASSERT_NOW(a_result_from_finish, out_v_r && !$past(out_v_r), $past(fin_go))
  `SBR_ASSERT_NEXT(a_header_clears, adv && is_header,
                   cnt_b_r == '0 && cnt_e_r == '0 && !last_seen_r && !first_seen_r)
  `SBR_ASSERT_NEXT(a_frame_restarts, adv && is_sample && s1_last_r, fall_r && !fany_r)
  `SBR_ASSERT_NEXT(a_first_loud_sticks, first_seen_r && !(adv && is_header), first_seen_r)

endmodule
